>>> rtl/wav_pcm16_mono_stream_parser_assert.svh
// Assertion macros for the parser, used by wav_parse_core.
// Each macro expects a signal named clk, and WAV_ASSERT also one named rst, in the scope where it is used.
`ifndef WAV_PCM16_MONO_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM16_MONO_STREAM_PARSER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define WAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WAV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wav_pkg.sv
package wav_pkg;

  // Chunk tags as they appear on the wire, first byte in the top bits.
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  // Length of every tag and size field in the headers.
  localparam logic [31:0] HdrBytes = 32'd4;

  localparam logic [15:0] FmtPcm   = 16'd1;
  localparam logic [15:0] Depth16  = 16'd16;
  localparam logic [15:0] MonoChan = 16'd1;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FMT   = 4'd5,
    PH_SKIP  = 4'd6,
    PH_PAD   = 4'd7,
    PH_DATA  = 4'd8,
    PH_IDLE  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NOT_RIFF    = 3'd0,
    ERR_EOF_HEADER  = 3'd1,
    ERR_DATA_NO_FMT = 3'd2,
    ERR_NOT_PCM     = 3'd3,
    ERR_NOT_16BIT   = 3'd4,
    ERR_NOT_MONO    = 3'd5,
    ERR_TRUNCATED   = 3'd6,
    ERR_NO_DATA     = 3'd7
  } err_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_of_stream;
  } beat_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic signed [15:0] sample_value;
    logic [31:0]        rate_hz;
    err_t               error_code;
    logic               final_flag;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] byte_counter;
    logic [31:0] chunk_length;
    logic [31:0] tag_shift;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [15:0] bit_depth;
    logic [31:0] rate_store;
    logic        fmt_seen;
    logic [7:0]  low_byte_hold;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:         PH_RIFF,
    byte_counter:  32'd0,
    chunk_length:  32'd0,
    tag_shift:     32'd0,
    format_tag:    16'd0,
    channel_count: 16'd0,
    bit_depth:     16'd0,
    rate_store:    32'd0,
    fmt_seen:      1'b0,
    low_byte_hold: 8'd0
  };

endpackage

>>> rtl/wav_byte_if.sv
interface wav_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

>>> rtl/wav_result_if.sv
interface wav_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [15:0] sample_value;
  logic [31:0]        rate_hz;
  logic [2:0]         error_code;
  logic               final_flag;

  modport source (
    output valid, output result_kind, output sample_value, output rate_hz,
    output error_code, output final_flag, input ready
  );
  modport sink (
    input valid, input result_kind, input sample_value, input rate_hz,
    input error_code, input final_flag, output ready
  );
endinterface

>>> rtl/wav_in_stage.sv
module wav_in_stage (
  input  logic            clk,
  input  logic            rst,
  wav_byte_if.sink        byte_stream,
  input  logic            step,
  output wav_pkg::beat_t  beat
);

  wav_pkg::beat_t held;

  // The register frees up in the same cycle that the parser consumes it.
  assign byte_stream.ready = !held.valid || step;
  assign beat = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (byte_stream.ready) begin
      held.valid <= byte_stream.valid;
    end
    if (byte_stream.valid && byte_stream.ready) begin
      held.data_byte     <= byte_stream.data_byte;
      held.end_of_stream <= byte_stream.end_of_stream;
    end
  end

endmodule

>>> rtl/wav_parse_core.sv
`include "wav_pcm16_mono_stream_parser_assert.svh"

module wav_parse_core (
  input  logic              clk,
  input  logic              rst,
  input  wav_pkg::beat_t    beat,
  input  logic              step,
  output wav_pkg::result_t  res
);

  wav_pkg::parse_state_t st;
  wav_pkg::parse_state_t st_next;
  wav_pkg::parse_state_t upd;

  logic               do_fail;
  logic               do_finish;
  logic               do_sample;
  logic               idle_byte;
  logic               file_end;
  wav_pkg::err_t      fail_code;
  logic [15:0]        smp;
  logic [31:0]        cnt_inc;
  logic [31:0]        tag_sh;
  logic [31:0]        len_new;
  logic [7:0]         b;
  logic               eos;

  always_comb begin
    b   = beat.data_byte;
    eos = beat.end_of_stream;
    upd = st;
    do_fail   = 1'b0;
    do_finish = 1'b0;
    do_sample = 1'b0;
    idle_byte = 1'b0;
    fail_code = wav_pkg::ERR_NOT_RIFF;
    smp       = 16'd0;
    cnt_inc   = st.byte_counter + 32'd1;
    tag_sh    = {st.tag_shift[23:0], b};
    len_new   = st.chunk_length;
    len_new[{st.byte_counter[1:0], 3'b000} +: 8] =
      st.chunk_length[{st.byte_counter[1:0], 3'b000} +: 8] | b;

    unique case (st.phase)
      wav_pkg::PH_RIFF: begin
        upd.tag_shift    = tag_sh;
        upd.byte_counter = cnt_inc;
        if (cnt_inc == wav_pkg::HdrBytes) begin
          upd.byte_counter = '0;
          if (tag_sh != wav_pkg::TagRiff) begin
            do_fail = 1'b1;
          end else begin
            upd.tag_shift = '0;
            upd.phase     = wav_pkg::PH_RSIZE;
          end
        end
        if (eos) begin
          do_fail = 1'b1;
        end
      end
      wav_pkg::PH_RSIZE: begin
        upd.byte_counter = cnt_inc;
        if (cnt_inc == wav_pkg::HdrBytes) begin
          upd.byte_counter = '0;
          upd.phase        = wav_pkg::PH_WAVE;
        end
        if (eos) begin
          do_fail = 1'b1;
        end
      end
      wav_pkg::PH_WAVE: begin
        upd.tag_shift    = tag_sh;
        upd.byte_counter = cnt_inc;
        if (cnt_inc == wav_pkg::HdrBytes) begin
          upd.byte_counter = '0;
          if (tag_sh != wav_pkg::TagWave) begin
            do_fail = 1'b1;
          end else begin
            upd.tag_shift = '0;
            upd.phase     = wav_pkg::PH_CID;
            if (eos) begin
              do_fail   = 1'b1;
              fail_code = wav_pkg::ERR_EOF_HEADER;
            end
          end
        end else if (eos) begin
          do_fail = 1'b1;
        end
      end
      wav_pkg::PH_CID: begin
        upd.tag_shift    = tag_sh;
        upd.byte_counter = cnt_inc;
        if (cnt_inc == wav_pkg::HdrBytes) begin
          upd.byte_counter = '0;
          upd.chunk_length = '0;
          upd.phase        = wav_pkg::PH_CSIZE;
        end
        if (eos) begin
          do_fail   = 1'b1;
          fail_code = wav_pkg::ERR_EOF_HEADER;
        end
      end
      wav_pkg::PH_CSIZE: begin
        upd.chunk_length = len_new;
        upd.byte_counter = cnt_inc;
        if (cnt_inc >= wav_pkg::HdrBytes) begin
          // Size complete: dispatch on the chunk id.
          upd.tag_shift    = '0;
          upd.byte_counter = '0;
          if (st.tag_shift == wav_pkg::TagFmt) begin
            upd.format_tag    = '0;
            upd.channel_count = '0;
            upd.bit_depth     = '0;
            upd.rate_store    = '0;
            if (len_new == 32'd0) begin
              upd.fmt_seen = 1'b1;
              upd.phase    = wav_pkg::PH_CID;
              fail_code    = wav_pkg::ERR_EOF_HEADER;
            end else begin
              upd.phase = wav_pkg::PH_FMT;
              fail_code = wav_pkg::ERR_NO_DATA;
            end
            do_fail = eos;
          end else if (st.tag_shift == wav_pkg::TagData) begin
            if (!st.fmt_seen) begin
              do_fail   = 1'b1;
              fail_code = wav_pkg::ERR_DATA_NO_FMT;
            end else if (st.format_tag != wav_pkg::FmtPcm) begin
              do_fail   = 1'b1;
              fail_code = wav_pkg::ERR_NOT_PCM;
            end else if (st.bit_depth != wav_pkg::Depth16) begin
              do_fail   = 1'b1;
              fail_code = wav_pkg::ERR_NOT_16BIT;
            end else if (st.channel_count != wav_pkg::MonoChan) begin
              do_fail   = 1'b1;
              fail_code = wav_pkg::ERR_NOT_MONO;
            end else if (len_new == 32'd0) begin
              do_finish = 1'b1;
            end else begin
              upd.phase = wav_pkg::PH_DATA;
              do_fail   = eos;
              fail_code = wav_pkg::ERR_TRUNCATED;
            end
          end else begin
            upd.phase = (len_new == 32'd0) ? wav_pkg::PH_CID : wav_pkg::PH_SKIP;
            do_fail   = eos;
            fail_code = wav_pkg::ERR_EOF_HEADER;
          end
        end else if (eos) begin
          do_fail   = 1'b1;
          fail_code = wav_pkg::ERR_EOF_HEADER;
        end
      end
      wav_pkg::PH_FMT: begin
        // Only the first sixteen body bytes carry fields.
        if (st.byte_counter[31:4] == '0) begin
          case (st.byte_counter[3:0])
            4'd0:  upd.format_tag[7:0]     = b;
            4'd1:  upd.format_tag[15:8]    = b;
            4'd2:  upd.channel_count[7:0]  = b;
            4'd3:  upd.channel_count[15:8] = b;
            4'd4, 4'd5, 4'd6, 4'd7: begin
              upd.rate_store[{st.byte_counter[1:0], 3'b000} +: 8] =
                st.rate_store[{st.byte_counter[1:0], 3'b000} +: 8] | b;
            end
            4'd14: upd.bit_depth[7:0]      = b;
            4'd15: upd.bit_depth[15:8]     = b;
            default: ;
          endcase
        end
        upd.byte_counter = cnt_inc;
        if (cnt_inc == st.chunk_length) begin
          upd.fmt_seen     = 1'b1;
          upd.byte_counter = '0;
          upd.phase = st.chunk_length[0] ? wav_pkg::PH_PAD : wav_pkg::PH_CID;
          fail_code = wav_pkg::ERR_EOF_HEADER;
        end else begin
          fail_code = wav_pkg::ERR_NO_DATA;
        end
        do_fail = eos;
      end
      wav_pkg::PH_SKIP: begin
        upd.byte_counter = cnt_inc;
        if (cnt_inc == st.chunk_length) begin
          upd.byte_counter = '0;
          upd.phase = st.chunk_length[0] ? wav_pkg::PH_PAD : wav_pkg::PH_CID;
        end
        do_fail   = eos;
        fail_code = wav_pkg::ERR_EOF_HEADER;
      end
      wav_pkg::PH_PAD: begin
        upd.byte_counter = '0;
        upd.phase        = wav_pkg::PH_CID;
        do_fail          = eos;
        fail_code        = wav_pkg::ERR_EOF_HEADER;
      end
      wav_pkg::PH_DATA: begin
        if (!st.byte_counter[0]) begin
          upd.low_byte_hold = b;
        end else begin
          smp = {b, st.low_byte_hold};
        end
        upd.byte_counter = cnt_inc;
        if (cnt_inc == st.chunk_length) begin
          // A sample completed by the last byte rides on the done result.
          do_finish = 1'b1;
        end else if (eos) begin
          do_fail   = 1'b1;
          fail_code = wav_pkg::ERR_TRUNCATED;
        end else begin
          do_sample = st.byte_counter[0];
        end
      end
      default: begin
        idle_byte = 1'b1;
      end
    endcase

    file_end = do_fail || do_finish || idle_byte;
    st_next  = upd;
    if (file_end) begin
      if (eos) begin
        st_next = wav_pkg::StateReset;
      end else begin
        st_next.phase = wav_pkg::PH_IDLE;
      end
    end

    res.valid        = step && (do_fail || do_finish || do_sample);
    res.kind         = do_fail ? wav_pkg::KIND_ERROR :
                       (do_finish ? wav_pkg::KIND_DONE : wav_pkg::KIND_SAMPLE);
    res.sample_value = do_fail ? 16'sd0 : $signed(smp);
    res.rate_hz      = upd.rate_store;
    res.error_code   = do_fail ? fail_code : wav_pkg::ERR_NOT_RIFF;
    res.final_flag   = do_fail || do_finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= wav_pkg::StateReset;
    end else if (step) begin
      st <= st_next;
    end
  end

  `WAV_ASSERT_ALWAYS(a_reset_phase, rst |=> st.phase == wav_pkg::PH_RIFF, "parser not rearmed after reset")
  `WAV_ASSERT(a_hdr_count, (st.phase == wav_pkg::PH_RIFF || st.phase == wav_pkg::PH_RSIZE || st.phase == wav_pkg::PH_WAVE || st.phase == wav_pkg::PH_CID || st.phase == wav_pkg::PH_CSIZE) |-> st.byte_counter < wav_pkg::HdrBytes, "header byte count out of range")
  `WAV_ASSERT(a_sample_in_data, (res.valid && res.kind == wav_pkg::KIND_SAMPLE) |-> (st.phase == wav_pkg::PH_DATA && !res.final_flag), "sample emitted outside data chunk")
  `WAV_ASSERT(a_eos_rearms, (step && beat.end_of_stream) |=> (st.phase == wav_pkg::PH_RIFF && st.byte_counter == 32'd0), "end of stream did not rearm the parser")

endmodule

>>> rtl/wav_out_stage.sv
module wav_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  wav_pkg::result_t  res,
  output logic              can_load,
  wav_result_if.source      result_stream
);

  wav_pkg::result_t held;

  assign can_load = !held.valid || result_stream.ready;

  assign result_stream.valid        = held.valid;
  assign result_stream.result_kind  = held.kind;
  assign result_stream.sample_value = held.sample_value;
  assign result_stream.rate_hz      = held.rate_hz;
  assign result_stream.error_code   = held.error_code;
  assign result_stream.final_flag   = held.final_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (can_load) begin
      held.valid <= res.valid;
    end
    if (can_load && res.valid) begin
      held.kind         <= res.kind;
      held.sample_value <= res.sample_value;
      held.rate_hz      <= res.rate_hz;
      held.error_code   <= res.error_code;
      held.final_flag   <= res.final_flag;
    end
  end

endmodule

>>> rtl/wav_pcm16_mono_stream_parser.sv
// RIFF/WAVE parser for 16-bit mono PCM. Feed the file one byte per beat on
// byte_stream and mark its last byte with end_of_stream. The parser checks the
// RIFF and WAVE tags, walks the chunks (skipping unknown ones and pad bytes),
// takes format, channels, sample rate and depth from the fmt chunk, and at the
// data chunk emits one signed sample per two bytes, then a done result with
// final_flag set. Any problem gives one error result with final_flag set;
// after a final result, bytes are ignored up to the next end-of-stream byte,
// and the byte after that starts a new file. It takes one byte every clock
// cycle with no bubbles while result_stream keeps up: the whole per-byte state
// update is combinational logic (its longest path is the 32-bit count
// increment and compare against the chunk size). A byte is held in the input
// register, and when it is parsed its result is registered in the output
// register and offered on result_stream. While a result waits to be taken,
// the input register can still take one more byte, and then byte_stream
// stalls until the result is taken.
module wav_pcm16_mono_stream_parser (
  input  logic          clk,
  input  logic          rst,
  wav_byte_if.sink      byte_stream,
  wav_result_if.source  result_stream
);

  wav_pkg::beat_t   beat;
  wav_pkg::result_t res;
  logic             can_load;
  logic             step;

  // A held byte is parsed when the result register can take whatever it
  // produces; bytes that produce nothing still wait for that, which keeps
  // the ordering simple and costs nothing while the result channel keeps up.
  assign step = beat.valid && can_load;

  wav_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .step        (step),
    .beat        (beat)
  );

  wav_parse_core u_core (
    .clk  (clk),
    .rst  (rst),
    .beat (beat),
    .step (step),
    .res  (res)
  );

  wav_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .can_load      (can_load),
    .result_stream (result_stream)
  );

endmodule

>>> dv/wav_pcm16_mono_stream_parser_tb.sv
module wav_pcm16_mono_stream_parser_tb;
  import wav_pkg::*;

  // Sample and done results carry a zero code field; that value is the same as
  // the first error code, so it gets a name of its own here.
  localparam err_t NoErr = ERR_NOT_RIFF;

  // Bytes per idling phase. The sender idles lightly and the receiver heavily
  // first, then the other way round, and the rest of the run goes flat out.
  localparam int PhaseBytes  = 270;
  localparam int RandomBytes = 800;

  // The scoreboard keeps its own copy of the parser state. Every accepted beat
  // advances that copy and may queue one expected result. Results coming off
  // the output channel are matched in order against that queue.
  class wav_result_board;
    parse_state_t st;
    result_t      awaited_results[$];
    int           mismatches;
    int           n_samples;
    int           n_done;
    int           n_errors;
    logic [7:0]   codes_seen;

    function new();
      st         = StateReset;
      mismatches = 0;
      n_samples  = 0;
      n_done     = 0;
      n_errors   = 0;
      codes_seen = '0;
    endfunction

    // Builds one result from the current rate. A done or an error ends the
    // file: the parser rearms at once on an end-of-stream byte and otherwise
    // waits for one.
    function bit emit(kind_t kind, logic [15:0] smp, err_t code, bit eos,
                      output result_t r);
      r.valid        = 1'b1;
      r.kind         = kind;
      r.sample_value = smp;
      r.rate_hz      = st.rate_store;
      r.error_code   = code;
      r.final_flag   = (kind != KIND_SAMPLE);
      if (kind != KIND_SAMPLE) begin
        if (eos) begin
          st = StateReset;
        end else begin
          st.phase = PH_IDLE;
        end
      end
      return 1'b1;
    endfunction

    function bit fail_if(bit eos, err_t code, output result_t r);
      if (eos) return emit(KIND_ERROR, 16'd0, code, eos, r);
      return 1'b0;
    endfunction

    // Called once the fourth size byte is in: decides what the chunk is.
    function bit open_chunk(bit eos, output result_t r);
      logic [31:0] id;
      id = st.tag_shift;
      st.tag_shift    = '0;
      st.byte_counter = '0;
      if (id == TagFmt) begin
        st.format_tag    = '0;
        st.channel_count = '0;
        st.bit_depth     = '0;
        st.rate_store    = '0;
        if (st.chunk_length == 0) begin
          st.fmt_seen = 1'b1;
          st.phase    = PH_CID;
          return fail_if(eos, ERR_EOF_HEADER, r);
        end
        st.phase = PH_FMT;
        return fail_if(eos, ERR_NO_DATA, r);
      end
      if (id == TagData) begin
        // The format checks run in a fixed order, so the first one that fails
        // names the error.
        if (!st.fmt_seen) return emit(KIND_ERROR, 16'd0, ERR_DATA_NO_FMT, eos, r);
        if (st.format_tag != FmtPcm) return emit(KIND_ERROR, 16'd0, ERR_NOT_PCM, eos, r);
        if (st.bit_depth != Depth16) return emit(KIND_ERROR, 16'd0, ERR_NOT_16BIT, eos, r);
        if (st.channel_count != MonoChan) return emit(KIND_ERROR, 16'd0, ERR_NOT_MONO, eos, r);
        if (st.chunk_length == 0) return emit(KIND_DONE, 16'd0, NoErr, eos, r);
        st.phase = PH_DATA;
        return fail_if(eos, ERR_TRUNCATED, r);
      end
      if (st.chunk_length == 0) begin
        st.phase = PH_CID;
      end else begin
        st.phase = PH_SKIP;
      end
      return fail_if(eos, ERR_EOF_HEADER, r);
    endfunction

    // Advances the parser by one byte. Returns 1 when the byte yields a result.
    function bit parse_byte(logic [7:0] b, bit eos, output result_t r);
      logic [31:0] off;
      logic [15:0] smp;
      bit          have;
      bit          is_riff;
      r = '0;
      case (st.phase)
        PH_RIFF, PH_WAVE: begin
          is_riff = (st.phase == PH_RIFF);
          st.tag_shift = {st.tag_shift[23:0], b};
          st.byte_counter++;
          if (st.byte_counter == HdrBytes) begin
            st.byte_counter = '0;
            if (st.tag_shift != (is_riff ? TagRiff : TagWave))
              return emit(KIND_ERROR, 16'd0, ERR_NOT_RIFF, eos, r);
            st.tag_shift = '0;
            if (is_riff) begin
              st.phase = PH_RSIZE;
            end else begin
              // A file that stops right after a good WAVE tag is a header
              // cut short, not a foreign file.
              st.phase = PH_CID;
              return fail_if(eos, ERR_EOF_HEADER, r);
            end
          end
          return fail_if(eos, ERR_NOT_RIFF, r);
        end
        PH_RSIZE: begin
          st.byte_counter++;
          if (st.byte_counter == HdrBytes) begin
            st.byte_counter = '0;
            st.phase = PH_WAVE;
          end
          return fail_if(eos, ERR_NOT_RIFF, r);
        end
        PH_CID: begin
          st.tag_shift = {st.tag_shift[23:0], b};
          st.byte_counter++;
          if (st.byte_counter == HdrBytes) begin
            st.byte_counter = '0;
            st.chunk_length = '0;
            st.phase = PH_CSIZE;
          end
          return fail_if(eos, ERR_EOF_HEADER, r);
        end
        PH_CSIZE: begin
          st.chunk_length |= {24'd0, b} << (8 * st.byte_counter[1:0]);
          st.byte_counter++;
          if (st.byte_counter >= HdrBytes) return open_chunk(eos, r);
          return fail_if(eos, ERR_EOF_HEADER, r);
        end
        PH_FMT: begin
          // Only the bytes within the chunk length are read, so a short fmt
          // chunk leaves the later fields at zero.
          off = st.byte_counter;
          case (off)
            32'd0: st.format_tag[7:0]     = b;
            32'd1: st.format_tag[15:8]    = b;
            32'd2: st.channel_count[7:0]  = b;
            32'd3: st.channel_count[15:8] = b;
            32'd4, 32'd5, 32'd6, 32'd7:
              st.rate_store |= {24'd0, b} << (8 * (off - 4));
            32'd14: st.bit_depth[7:0]     = b;
            32'd15: st.bit_depth[15:8]    = b;
            default: ;
          endcase
          st.byte_counter++;
          if (st.byte_counter == st.chunk_length) begin
            st.fmt_seen     = 1'b1;
            st.byte_counter = '0;
            if (st.chunk_length[0]) begin
              st.phase = PH_PAD;
            end else begin
              st.phase = PH_CID;
            end
            return fail_if(eos, ERR_EOF_HEADER, r);
          end
          return fail_if(eos, ERR_NO_DATA, r);
        end
        PH_SKIP: begin
          st.byte_counter++;
          if (st.byte_counter == st.chunk_length) begin
            st.byte_counter = '0;
            if (st.chunk_length[0]) begin
              st.phase = PH_PAD;
            end else begin
              st.phase = PH_CID;
            end
          end
          return fail_if(eos, ERR_EOF_HEADER, r);
        end
        PH_PAD: begin
          st.byte_counter = '0;
          st.phase = PH_CID;
          return fail_if(eos, ERR_EOF_HEADER, r);
        end
        PH_DATA: begin
          have = 1'b0;
          smp  = '0;
          if (!st.byte_counter[0]) begin
            st.low_byte_hold = b;
          end else begin
            smp  = {b, st.low_byte_hold};
            have = 1'b1;
          end
          st.byte_counter++;
          // The last sample of the chunk rides on the done result, and an
          // odd trailing byte is simply dropped.
          if (st.byte_counter == st.chunk_length)
            return emit(KIND_DONE, have ? smp : 16'd0, NoErr, eos, r);
          if (eos) return emit(KIND_ERROR, 16'd0, ERR_TRUNCATED, eos, r);
          if (have) return emit(KIND_SAMPLE, smp, NoErr, eos, r);
          return 1'b0;
        end
        default: begin
          if (eos) begin
            st = StateReset;
          end else begin
            st.phase = PH_IDLE;
          end
          return 1'b0;
        end
      endcase
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task note_byte(logic [7:0] b, bit eos);
      result_t r;
      if (parse_byte(b, eos, r)) awaited_results.push_back(r);
    endtask

    task check_result(logic [1:0] kind, logic [15:0] smp, logic [31:0] rate,
                      logic [2:0] code, logic fin);
      result_t want;
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d sample %h code %0d",
                                kind, smp, code));
        return;
      end
      want = awaited_results.pop_front();
      if (kind != want.kind || smp != want.sample_value || rate != want.rate_hz ||
          code != want.error_code || fin != want.final_flag)
        flag_mismatch($sformatf(
          "got kind %0d smp %h rate %h code %0d fin %b, want %0d %h %h %0d %b",
          kind, smp, rate, code, fin, want.kind, want.sample_value, want.rate_hz,
          want.error_code, want.final_flag));
      case (want.kind)
        KIND_SAMPLE: n_samples++;
        KIND_DONE:   n_done++;
        default: begin
          n_errors++;
          codes_seen[want.error_code] = 1'b1;
        end
      endcase
    endtask
  endclass

  logic clk;
  logic rst;

  wav_byte_if   byte_if();
  wav_result_if result_if();

  wav_pcm16_mono_stream_parser dut (
    .clk           (clk),
    .rst           (rst),
    .byte_stream   (byte_if),
    .result_stream (result_if)
  );

  wav_result_board results_board = new();

  logic [7:0] file_bytes[$];
  logic [7:0] chunk_body[$];
  int         source_idle_pct = 16;
  int         sink_idle_pct   = 60;
  int         bytes_sent      = 0;
  int         files_sent      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hard stop in case the handshake hangs.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver samples each result beat on the clock edge and then decides
  // at random whether to stall for the next cycle.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready)
        results_board.check_result(result_if.result_kind, result_if.sample_value,
                                   result_if.rate_hz, result_if.error_code,
                                   result_if.final_flag);
      result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Random byte that lands on the extreme values a good part of the time.
  function automatic logic [7:0] rand_byte();
    logic [31:0] w;
    w = $urandom;
    case (w[31:29])
      3'd0: return 8'h00;
      3'd1: return 8'hFF;
      3'd2: return 8'h80;
      3'd3: return 8'h7F;
      default: return w[7:0];
    endcase
  endfunction

  // Tags go out first byte first; sizes go out little-endian.
  task automatic put_tag(logic [31:0] t);
    file_bytes.push_back(t[31:24]);
    file_bytes.push_back(t[23:16]);
    file_bytes.push_back(t[15:8]);
    file_bytes.push_back(t[7:0]);
  endtask

  task automatic put_le32(logic [31:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[23:16]);
    file_bytes.push_back(v[31:24]);
  endtask

  // Writes a chunk header and its body from chunk_body, topped up with random
  // bytes. A huge size only gets a few body bytes, so whatever follows in the
  // file is swallowed as body and the file ends inside the chunk.
  task automatic add_chunk(logic [31:0] id, logic [31:0] len);
    int n;
    put_tag(id);
    put_le32(len);
    n = (len > 40) ? 3 : int'(len);
    for (int i = 0; i < n; i++)
      file_bytes.push_back(i < chunk_body.size() ? chunk_body[i] : rand_byte());
    if (len <= 40 && len[0]) file_bytes.push_back(rand_byte());
  endtask

  // A fmt chunk that is mostly PCM/16-bit/mono with a random rate. Its length
  // is mostly the usual 16 or 18 bytes, sometimes short, now and then huge.
  task automatic add_fmt();
    logic [31:0] w;
    logic [31:0] len;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [15:0] depth;
    int          pick;
    w     = $urandom;
    tag   = ($urandom_range(9) == 0) ? w[15:0] : FmtPcm;
    chans = ($urandom_range(9) == 0) ? w[31:16] : MonoChan;
    w     = $urandom;
    depth = ($urandom_range(9) == 0) ? w[15:0] : Depth16;
    chunk_body.delete();
    chunk_body.push_back(tag[7:0]);
    chunk_body.push_back(tag[15:8]);
    chunk_body.push_back(chans[7:0]);
    chunk_body.push_back(chans[15:8]);
    w = $urandom;
    for (int i = 0; i < 4; i++) chunk_body.push_back(w[8*i +: 8]);
    for (int i = 0; i < 6; i++) chunk_body.push_back(rand_byte());
    chunk_body.push_back(depth[7:0]);
    chunk_body.push_back(depth[15:8]);
    pick = $urandom_range(99);
    if (pick < 55) begin
      len = 32'd16;
    end else if (pick < 70) begin
      len = 32'd18;
    end else if (pick < 92) begin
      len = $urandom_range(17);
    end else begin
      len = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
    end
    add_chunk(TagFmt, len);
  endtask

  // One file of random shape. Most are well formed up to the data chunk so
  // that the samples and the data checks get exercised; the rest are noise,
  // damaged tags, files cut at a random byte, or files with bytes after the
  // end of the data chunk.
  task automatic build_file();
    logic [31:0] tag;
    logic [31:0] len;
    int          pick;
    file_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 16)) file_bytes.push_back(rand_byte());
      return;
    end
    tag = TagRiff;
    if (pick < 14) tag[$urandom_range(31)] ^= 1'b1;
    put_tag(tag);
    put_le32($urandom);
    tag = TagWave;
    if (pick >= 14 && pick < 20) tag[$urandom_range(31)] ^= 1'b1;
    put_tag(tag);
    chunk_body.delete();
    if ($urandom_range(9) < 3)
      add_chunk($urandom, ($urandom_range(19) == 0) ? 32'hFFFF_FFFF : $urandom_range(6));
    if ($urandom_range(9) != 0) add_fmt();
    chunk_body.delete();
    if ($urandom_range(9) == 0) add_chunk($urandom, $urandom_range(5));
    if ($urandom_range(9) == 0) add_fmt();
    chunk_body.delete();
    len = ($urandom_range(12) == 0) ? ($urandom | 32'h100) : $urandom_range(12);
    add_chunk(TagData, len);
    if ($urandom_range(3) == 0)
      file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
    else if ($urandom_range(2) == 0)
      repeat ($urandom_range(1, 3)) file_bytes.push_back(rand_byte());
  endtask

  // Offers one byte, idling first at the current rate, and waits until the
  // beat is taken. Valid stays high into the next call when no idle follows.
  task automatic send_byte(logic [7:0] b, logic last);
    if (bytes_sent < PhaseBytes) begin
      source_idle_pct = 16;
      sink_idle_pct   = 60;
    end else if (bytes_sent < 2 * PhaseBytes) begin
      source_idle_pct = 60;
      sink_idle_pct   = 16;
    end else begin
      source_idle_pct = 0;
      sink_idle_pct   = 0;
    end
    while ($urandom_range(99) < source_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid         <= 1'b1;
    byte_if.data_byte     <= b;
    byte_if.end_of_stream <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    results_board.note_byte(b, last);
    bytes_sent++;
  endtask

  // Sends the built file with end of stream on its last byte.
  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  initial begin
    int drain;
    rst                   <= 1'b1;
    byte_if.valid         <= 1'b0;
    byte_if.data_byte     <= '0;
    byte_if.end_of_stream <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed files. A wrong RIFF tag ending the stream on its fourth byte.
    put_tag(TagRiff ^ 32'h0000_0001);
    send_file();
    // A stream that stops two bytes into the RIFF tag.
    file_bytes.delete();
    file_bytes.push_back(TagRiff[31:24]);
    file_bytes.push_back(TagRiff[23:16]);
    send_file();
    // A complete twelve-byte header and nothing after it.
    file_bytes.delete();
    put_tag(TagRiff);
    put_le32(32'd4);
    put_tag(TagWave);
    send_file();
    // A wrong RIFF tag without end of stream: the next byte is ignored and,
    // being marked as the last one, rearms the parser.
    file_bytes.delete();
    put_tag(TagRiff ^ 32'h0100_0000);
    file_bytes.push_back(8'hFF);
    send_file();

    while (bytes_sent < RandomBytes) begin
      build_file();
      send_file();
    end
    byte_if.valid <= 1'b0;

    // Wait for the outstanding results, then keep the clock running to catch any
    // stray beat the parser might still put out.
    drain = 0;
    while (results_board.awaited_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (results_board.awaited_results.size() != 0)
      results_board.flag_mismatch($sformatf("%0d expected results never came",
                                            results_board.awaited_results.size()));

    $display("Sent %0d files in %0d bytes; checked %0d samples, %0d done, %0d errors.",
             files_sent, bytes_sent, results_board.n_samples, results_board.n_done,
             results_board.n_errors);
    $display("Error codes seen (bit per code): %b; mismatches: %0d.",
             results_board.codes_seen, results_board.mismatches);
    if (results_board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
